[src/nmea_rmc_sentence_parser_unit_defines.svh]
// ----------------------------------------------------------------------------
// NMEA RMC parser assertion macros
// Concurrent check helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_SENTENCE_PARSER_UNIT_DEFINES_SVH
`define NMEA_RMC_SENTENCE_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NRMC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nmea rmc parser: same-cycle check failed");
// next-cycle implication
`define NRMC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nmea rmc parser: next-cycle check failed");
`else
`define NRMC_ASSERT_IMP(lbl, ante, cons)
`define NRMC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[src/nmea_rmc_pkg.sv]
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Shared result type, character codes, limits and fixed-point helpers.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

    // result item, first member at the top so hours lands in the low bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [2:0]  fix_mode;
        logic [6:0]  year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [29:0] speed;
        logic [1:0]  hemispheres;
        logic [30:0] longitude;
        logic [29:0] latitude;
        logic        fix_valid;
        logic [6:0]  seconds;
        logic [6:0]  minutes;
        logic [6:0]  hours;
    } rmc_result_t;

    localparam int RESULT_W = $bits(rmc_result_t);

    typedef enum logic [2:0] {
        MODE_AUTO   = 3'd0,
        MODE_DIFF   = 3'd1,
        MODE_RTK    = 3'd2,
        MODE_FLOAT  = 3'd3,
        MODE_EST    = 3'd4,
        MODE_OTHER  = 3'd5
    } fix_mode_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    // field numbers within the sentence
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_DATE   = 4'd9;
    localparam logic [3:0] FLD_LAST   = 4'd15;

    localparam logic [2:0] POS_FRAC_DIGITS = 3'd5;
    localparam logic [2:0] SPD_FRAC_DIGITS = 3'd3;
    localparam logic [2:0] NUM_DONE        = 3'd7;

    localparam logic [31:0] LAT_MAX = 32'd900000000;
    localparam logic [31:0] LON_MAX = 32'd1800000000;
    localparam logic [31:0] SPD_MAX = 32'd999999999;

    function automatic logic [19:0] pow10(input logic [2:0] k);
        logic [19:0] r;
        case (k)
            3'd0:    r = 20'd1;
            3'd1:    r = 20'd10;
            3'd2:    r = 20'd100;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd10000;
            3'd5:    r = 20'd100000;
            3'd6:    r = 20'd1000000;
            default: r = 20'd1;
        endcase
        return r;
    endfunction

endpackage

[src/nmea_rmc_num.sv]
// ----------------------------------------------------------------------------
// NMEA RMC number unit
// Saturating decimal accumulate, fraction scaling and per-field clamp.
// ----------------------------------------------------------------------------
module nmea_rmc_num (
    input  logic [31:0] accum,
    input  logic [2:0]  fraction_count,
    input  logic [3:0]  field_index,
    input  logic [3:0]  digit,
    output logic [2:0]  frac_digits,
    output logic [31:0] accum_digit,
    output logic [31:0] accum_scaled,
    output logic [30:0] value
);

    logic [35:0] times_ten;
    logic [2:0]  shift_k;
    logic [51:0] product;
    logic [31:0] cap;
    logic [31:0] pre_clamp;

    assign frac_digits = (field_index == nmea_rmc_pkg::FLD_SPEED) ?
                         nmea_rmc_pkg::SPD_FRAC_DIGITS : nmea_rmc_pkg::POS_FRAC_DIGITS;

    // accum * 10 + digit, saturating at 32 bits
    assign times_ten   = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {32'd0, digit};
    assign accum_digit = (|times_ten[35:32]) ? 32'hFFFF_FFFF : times_ten[31:0];

    // pad missing fraction digits; saturates exactly when the product overflows
    assign shift_k      = 3'(frac_digits - fraction_count);
    assign product      = accum * nmea_rmc_pkg::pow10(shift_k);
    assign accum_scaled = (|product[51:32]) ? 32'hFFFF_FFFF : product[31:0];

    always_comb
    begin
        case (field_index)
            nmea_rmc_pkg::FLD_LAT: cap = nmea_rmc_pkg::LAT_MAX;
            nmea_rmc_pkg::FLD_LON: cap = nmea_rmc_pkg::LON_MAX;
            default:               cap = nmea_rmc_pkg::SPD_MAX;
        endcase
        if (fraction_count != nmea_rmc_pkg::NUM_DONE && fraction_count <= frac_digits)
        begin
            pre_clamp = accum_scaled;
        end
        else
        begin
            pre_clamp = accum;
        end
        value = (pre_clamp > cap) ? cap[30:0] : pre_clamp[30:0];
    end

endmodule

[src/nmea_rmc_core.sv]
// ----------------------------------------------------------------------------
// NMEA RMC parse core
// Sentence and field tracking, field decode and the kept fix values.
// ----------------------------------------------------------------------------
module nmea_rmc_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                char_c,
    output logic                      emit,
    output nmea_rmc_pkg::rmc_result_t result
);

    logic        in_sentence_reg, in_sentence_next;
    logic [3:0]  field_index_reg, field_index_next;
    logic        seen_point_reg, seen_point_next;
    logic [2:0]  fraction_count_reg, fraction_count_next;
    logic [31:0] number_accum_reg, number_accum_next;
    logic [23:0] pair_digits_reg, pair_digits_next;
    logic [7:0]  first_char_reg, first_char_next;
    logic [20:0] time_reg, time_next;
    logic [29:0] lat_reg, lat_next;
    logic [30:0] lon_reg, lon_next;
    logic [29:0] speed_reg, speed_next;
    logic [20:0] date_reg, date_next;
    logic [1:0]  hemi_reg, hemi_next;
    logic        status_reg, status_next;

    logic        is_digit;
    logic [2:0]  frac_digits;
    logic [31:0] accum_digit;
    logic [31:0] accum_scaled;
    logic [30:0] num_value;
    logic [20:0] pairs;
    logic [2:0]  mode;

    function automatic logic [6:0] pair_val(input logic [7:0] bcd);
        return 7'({3'b000, bcd[7:4]} * 7'd10 + {3'b000, bcd[3:0]});
    endfunction

    function automatic logic [2:0] mode_code(input logic [7:0] c);
        logic [2:0] m;
        case (c)
            nmea_rmc_pkg::CH_A: m = nmea_rmc_pkg::MODE_AUTO;
            nmea_rmc_pkg::CH_D: m = nmea_rmc_pkg::MODE_DIFF;
            nmea_rmc_pkg::CH_R: m = nmea_rmc_pkg::MODE_RTK;
            nmea_rmc_pkg::CH_F: m = nmea_rmc_pkg::MODE_FLOAT;
            nmea_rmc_pkg::CH_E: m = nmea_rmc_pkg::MODE_EST;
            default:            m = nmea_rmc_pkg::MODE_OTHER;
        endcase
        return m;
    endfunction

    assign is_digit = (char_c >= nmea_rmc_pkg::CH_ZERO) && (char_c <= nmea_rmc_pkg::CH_NINE);
    assign pairs    = {pair_val(pair_digits_reg[23:16]), pair_val(pair_digits_reg[15:8]),
                       pair_val(pair_digits_reg[7:0])};
    assign mode     = mode_code(first_char_reg);

    nmea_rmc_num u_num (
        .accum          (number_accum_reg),
        .fraction_count (fraction_count_reg),
        .field_index    (field_index_reg),
        .digit          (char_c[3:0]),      // low nibble of '0'..'9' is the digit
        .frac_digits    (frac_digits),
        .accum_digit    (accum_digit),
        .accum_scaled   (accum_scaled),
        .value          (num_value)
    );

    always_comb
    begin
        in_sentence_next    = in_sentence_reg;
        field_index_next    = field_index_reg;
        seen_point_next     = seen_point_reg;
        fraction_count_next = fraction_count_reg;
        number_accum_next   = number_accum_reg;
        pair_digits_next    = pair_digits_reg;
        first_char_next     = first_char_reg;
        time_next           = time_reg;
        lat_next            = lat_reg;
        lon_next            = lon_reg;
        speed_next          = speed_reg;
        date_next           = date_reg;
        hemi_next           = hemi_reg;
        status_next         = status_reg;
        emit                = 1'b0;

        if (char_c == nmea_rmc_pkg::CH_DOLLAR)
        begin
            in_sentence_next    = 1'b1;
            field_index_next    = 4'd0;
            seen_point_next     = 1'b0;
            fraction_count_next = 3'd0;
            number_accum_next   = 32'd0;
            pair_digits_next    = 24'd0;
            first_char_next     = 8'd0;
        end
        else if (in_sentence_reg &&
                 (char_c == nmea_rmc_pkg::CH_COMMA || char_c == nmea_rmc_pkg::CH_STAR))
        begin
            // close the current field
            case (field_index_reg)
                nmea_rmc_pkg::FLD_TIME:   time_next   = pairs;
                nmea_rmc_pkg::FLD_STATUS: status_next = (first_char_reg == nmea_rmc_pkg::CH_A);
                nmea_rmc_pkg::FLD_LAT:    lat_next    = num_value[29:0];
                nmea_rmc_pkg::FLD_NS:
                begin
                    if (first_char_reg == nmea_rmc_pkg::CH_N)
                    begin
                        hemi_next[0] = 1'b0;
                    end
                    else if (first_char_reg == nmea_rmc_pkg::CH_S)
                    begin
                        hemi_next[0] = 1'b1;
                    end
                end
                nmea_rmc_pkg::FLD_LON:    lon_next    = num_value;
                nmea_rmc_pkg::FLD_EW:
                begin
                    if (first_char_reg == nmea_rmc_pkg::CH_E)
                    begin
                        hemi_next[1] = 1'b0;
                    end
                    else if (first_char_reg == nmea_rmc_pkg::CH_W)
                    begin
                        hemi_next[1] = 1'b1;
                    end
                end
                nmea_rmc_pkg::FLD_SPEED:  speed_next  = num_value[29:0];
                nmea_rmc_pkg::FLD_DATE:   date_next   = pairs;
                default: ;
            endcase
            seen_point_next     = 1'b0;
            fraction_count_next = 3'd0;
            number_accum_next   = 32'd0;
            pair_digits_next    = 24'd0;
            first_char_next     = 8'd0;
            if (field_index_reg != nmea_rmc_pkg::FLD_LAST)
            begin
                field_index_next = field_index_reg + 4'd1;
            end
            if (char_c == nmea_rmc_pkg::CH_STAR)
            begin
                in_sentence_next = 1'b0;
                field_index_next = 4'd0;
                emit             = 1'b1;
            end
        end
        else if (in_sentence_reg)
        begin
            if (first_char_reg == 8'd0)
            begin
                first_char_next = char_c;
            end
            if (field_index_reg == nmea_rmc_pkg::FLD_TIME ||
                field_index_reg == nmea_rmc_pkg::FLD_DATE)
            begin
                // integer part only, as BCD pairs
                if (!seen_point_reg)
                begin
                    if (is_digit)
                    begin
                        pair_digits_next = {pair_digits_reg[19:0], char_c[3:0]};
                    end
                    else
                    begin
                        seen_point_next = 1'b1;
                    end
                end
            end
            else if ((field_index_reg == nmea_rmc_pkg::FLD_LAT ||
                      field_index_reg == nmea_rmc_pkg::FLD_LON ||
                      field_index_reg == nmea_rmc_pkg::FLD_SPEED) &&
                     fraction_count_reg != nmea_rmc_pkg::NUM_DONE)
            begin
                if (is_digit)
                begin
                    if (!seen_point_reg || fraction_count_reg < frac_digits)
                    begin
                        number_accum_next = accum_digit;
                        if (seen_point_reg)
                        begin
                            fraction_count_next = fraction_count_reg + 3'd1;
                        end
                    end
                end
                else if (char_c == nmea_rmc_pkg::CH_POINT && !seen_point_reg)
                begin
                    seen_point_next = 1'b1;
                end
                else
                begin
                    // any other character freezes the number at full scale
                    if (fraction_count_reg <= frac_digits)
                    begin
                        number_accum_next = accum_scaled;
                    end
                    seen_point_next     = 1'b1;
                    fraction_count_next = nmea_rmc_pkg::NUM_DONE;
                end
            end
        end
    end

    always_comb
    begin
        result             = '0;
        result.hours       = time_next[20:14];
        result.minutes     = time_next[13:7];
        result.seconds     = time_next[6:0];
        result.fix_valid   = status_next;
        result.latitude    = lat_next;
        result.longitude   = lon_next;
        result.hemispheres = hemi_next;
        result.speed       = speed_next;
        result.day         = date_next[20:14];
        result.month       = date_next[13:7];
        result.year        = date_next[6:0];
        result.fix_mode    = mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg    <= 1'b0;
            field_index_reg    <= 4'd0;
            seen_point_reg     <= 1'b0;
            fraction_count_reg <= 3'd0;
            number_accum_reg   <= 32'd0;
            pair_digits_reg    <= 24'd0;
            first_char_reg     <= 8'd0;
            time_reg           <= 21'd0;
            lat_reg            <= 30'd0;
            lon_reg            <= 31'd0;
            speed_reg          <= 30'd0;
            date_reg           <= 21'd0;
            hemi_reg           <= 2'd0;
            status_reg         <= 1'b0;
        end
        else if (step)
        begin
            in_sentence_reg    <= in_sentence_next;
            field_index_reg    <= field_index_next;
            seen_point_reg     <= seen_point_next;
            fraction_count_reg <= fraction_count_next;
            number_accum_reg   <= number_accum_next;
            pair_digits_reg    <= pair_digits_next;
            first_char_reg     <= first_char_next;
            time_reg           <= time_next;
            lat_reg            <= lat_next;
            lon_reg            <= lon_next;
            speed_reg          <= speed_next;
            date_reg           <= date_next;
            hemi_reg           <= hemi_next;
            status_reg         <= status_next;
        end
    end

endmodule

[src/nmea_rmc_obuf.sv]
// ----------------------------------------------------------------------------
// NMEA RMC output register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module nmea_rmc_obuf (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  nmea_rmc_pkg::rmc_result_t load_data,
    output logic                      free,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [nmea_rmc_pkg::RESULT_W-1:0] m_tdata
);

    logic                      valid_reg, valid_next;
    nmea_rmc_pkg::rmc_result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

[src/nmea_rmc_sentence_parser_unit.sv]
// ----------------------------------------------------------------------------
// NMEA RMC sentence parser
// Parses an RMC sentence one character per transaction; one fix per '*' that ends a sentence.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit up)
//  s_axis    in   char_in[7:0]
//  m_axis    out  hours, minutes, seconds, fix_valid, latitude, longitude,
//                 hemispheres, speed, day, month, year, fix_mode, zero pad
//
// One character per cycle when not stalled: input register, one pass of decode
// logic (the 32x20 fraction scaling multiply sets the path), result register.
// A '*' result passes the input register, then the result register, where it
// waits until taken.
// The input side stalls only while a '*' waits on a full, unread result register.
// Reset clears all sentence state and kept values to zero.
// ----------------------------------------------------------------------------
`include "nmea_rmc_sentence_parser_unit_defines.svh"

module nmea_rmc_sentence_parser_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_in
    output logic         m_tvalid,
    input  logic         m_tready,
    // [6:0] hours, [13:7] minutes, [20:14] seconds, [21] fix_valid,
    // [51:22] latitude, [82:52] longitude, [84:83] hemispheres,
    // [114:85] speed, [121:115] day, [128:122] month, [135:129] year,
    // [138:136] fix_mode, [143:139] zero
    output logic [143:0] m_tdata
);

    logic                      in_valid_reg, in_valid_next;
    logic [7:0]                char_reg;
    logic                      core_emit;
    logic                      emit;
    logic                      out_free;
    logic                      advance;
    logic                      load;
    nmea_rmc_pkg::rmc_result_t core_result;
    nmea_rmc_pkg::rmc_result_t out_view;

    assign emit     = in_valid_reg && core_emit;
    assign advance  = in_valid_reg && (!core_emit || out_free);
    assign load     = advance && emit;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
        end
    end

    nmea_rmc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .char_c (char_reg),
        .emit   (core_emit),
        .result (core_result)
    );

    nmea_rmc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (core_result),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign out_view = m_tdata;

    // a held character only waits behind an unread result
    `NRMC_ASSERT_IMP(a_stall_cause, in_valid_reg && !advance, m_tvalid && !m_tready && core_emit)
    // results stay within their clamps
    `NRMC_ASSERT_IMP(a_clamped, m_tvalid, (out_view.latitude <= nmea_rmc_pkg::LAT_MAX[29:0]) && (out_view.longitude <= nmea_rmc_pkg::LON_MAX[30:0]) && (out_view.speed <= nmea_rmc_pkg::SPD_MAX[29:0]))
    // a loaded result shows up with a legal mode code
    `NRMC_ASSERT_NXT(a_load_shows, load, m_tvalid && (out_view.fix_mode <= nmea_rmc_pkg::MODE_OTHER))

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// NMEA RMC sentence parser testbench
// Streams sentence text into the parser one character per transaction and
// compares each fix against a cycle-free software parse of the same text.
// Directed sentences come first, then random sentences with broken parts and
// line noise, with random idle gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS       = 1400;
    localparam int CALM_ITEMS  = 300;
    localparam int LONG_HOLD   = 200;
    localparam int QUIET_LIMIT = 2000;

    localparam int          POS_DIGITS = 5;
    localparam int          SPD_DIGITS = 3;
    localparam logic [2:0]  NUM_ENDED  = 3'd7;
    localparam logic [31:0] LAT_CAP    = 32'd900000000;
    localparam logic [31:0] LON_CAP    = 32'd1800000000;
    localparam logic [31:0] SPD_CAP    = 32'd999999999;

    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    logic [7:0]                char_q[$];
    nmea_rmc_pkg::rmc_result_t fix_q[$];

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int errors = 0;
    int n_items = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    nmea_rmc_pkg::rmc_result_t fix_pred;
    nmea_rmc_pkg::rmc_result_t fix_want;
    nmea_rmc_pkg::rmc_result_t fix_got;

    // parser state mirror
    logic                      p_active = 1'b0;
    logic [3:0]                p_field = 4'd0;
    logic                      p_point = 1'b0;
    logic [2:0]                p_frac = 3'd0;
    logic [31:0]               p_acc = 32'd0;
    logic [23:0]               p_bcd = 24'd0;
    logic [7:0]                p_first = 8'h00;
    nmea_rmc_pkg::rmc_result_t p_kept = '0;

    nmea_rmc_sentence_parser_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sentence parse used for prediction
    // ------------------------------------------------------------------
    function automatic logic [31:0] scale10(input logic [31:0] v, input int k);
        repeat (k)
            v = (v > 32'd429496729) ? 32'hFFFF_FFFF : v * 32'd10;
        return v;
    endfunction

    function automatic logic [31:0] num_value(input int digits, input logic [31:0] cap);
        logic [31:0] v;
        v = p_acc;
        if (p_frac != NUM_ENDED && p_frac <= digits)
            v = scale10(v, digits - p_frac);
        return (v > cap) ? cap : v;
    endfunction

    // pairs counted from the right: 0 is seconds/year
    function automatic logic [6:0] pair_at(input int i);
        logic [3:0] lo;
        logic [3:0] hi;
        lo = p_bcd[8 * i +: 4];
        hi = p_bcd[8 * i + 4 +: 4];
        return 7'(hi * 10 + lo);
    endfunction

    function automatic void clear_field();
        p_point = 1'b0;
        p_frac  = 3'd0;
        p_acc   = 32'd0;
        p_bcd   = 24'd0;
        p_first = 8'h00;
    endfunction

    function automatic void close_field();
        case (p_field)
            nmea_rmc_pkg::FLD_TIME:
            begin
                p_kept.hours   = pair_at(2);
                p_kept.minutes = pair_at(1);
                p_kept.seconds = pair_at(0);
            end
            nmea_rmc_pkg::FLD_STATUS: p_kept.fix_valid = (p_first == nmea_rmc_pkg::CH_A);
            nmea_rmc_pkg::FLD_LAT:    p_kept.latitude = 30'(num_value(POS_DIGITS, LAT_CAP));
            nmea_rmc_pkg::FLD_NS:
            begin
                if (p_first == nmea_rmc_pkg::CH_N)
                    p_kept.hemispheres[0] = 1'b0;
                else if (p_first == nmea_rmc_pkg::CH_S)
                    p_kept.hemispheres[0] = 1'b1;
            end
            nmea_rmc_pkg::FLD_LON:    p_kept.longitude = 31'(num_value(POS_DIGITS, LON_CAP));
            nmea_rmc_pkg::FLD_EW:
            begin
                if (p_first == nmea_rmc_pkg::CH_E)
                    p_kept.hemispheres[1] = 1'b0;
                else if (p_first == nmea_rmc_pkg::CH_W)
                    p_kept.hemispheres[1] = 1'b1;
            end
            nmea_rmc_pkg::FLD_SPEED:  p_kept.speed = 30'(num_value(SPD_DIGITS, SPD_CAP));
            nmea_rmc_pkg::FLD_DATE:
            begin
                p_kept.day   = pair_at(2);
                p_kept.month = pair_at(1);
                p_kept.year  = pair_at(0);
            end
            default: ;
        endcase
        clear_field();
        if (p_field < nmea_rmc_pkg::FLD_LAST)
            p_field = p_field + 4'd1;
    endfunction

    function automatic bit rmc_parse_char(input logic [7:0] c,
                                          output nmea_rmc_pkg::rmc_result_t fix);
        bit                      digit;
        int                      digits;
        logic [63:0]             t;
        nmea_rmc_pkg::fix_mode_t mode;
        fix = '0;
        digit = (c >= nmea_rmc_pkg::CH_ZERO && c <= nmea_rmc_pkg::CH_NINE);
        if (c == nmea_rmc_pkg::CH_DOLLAR)
        begin
            p_active = 1'b1;
            p_field  = 4'd0;
            clear_field();
            return 1'b0;
        end
        if (!p_active)
            return 1'b0;
        if (c == nmea_rmc_pkg::CH_COMMA)
        begin
            close_field();
            return 1'b0;
        end
        if (c != nmea_rmc_pkg::CH_STAR)
        begin
            if (p_first == 8'h00)
                p_first = c;
            if (p_field == nmea_rmc_pkg::FLD_TIME || p_field == nmea_rmc_pkg::FLD_DATE)
            begin
                // integer part only, as a shift register of BCD digits
                if (!p_point)
                begin
                    if (digit)
                        p_bcd = {p_bcd[19:0], 4'(c - nmea_rmc_pkg::CH_ZERO)};
                    else
                        p_point = 1'b1;
                end
            end
            else if (p_field == nmea_rmc_pkg::FLD_LAT || p_field == nmea_rmc_pkg::FLD_LON ||
                     p_field == nmea_rmc_pkg::FLD_SPEED)
            begin
                digits = (p_field == nmea_rmc_pkg::FLD_SPEED) ? SPD_DIGITS : POS_DIGITS;
                if (p_frac != NUM_ENDED)
                begin
                    if (digit)
                    begin
                        if (!p_point || p_frac < digits)
                        begin
                            t = 64'(p_acc) * 64'd10 + 64'(c - nmea_rmc_pkg::CH_ZERO);
                            p_acc = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
                            if (p_point)
                                p_frac = p_frac + 3'd1;
                        end
                    end
                    else if (c == nmea_rmc_pkg::CH_POINT && !p_point)
                        p_point = 1'b1;
                    else
                    begin
                        // any other character freezes the number
                        if (p_frac <= digits)
                            p_acc = scale10(p_acc, digits - p_frac);
                        p_point = 1'b1;
                        p_frac  = NUM_ENDED;
                    end
                end
            end
            return 1'b0;
        end
        case (p_first)
            nmea_rmc_pkg::CH_A: mode = nmea_rmc_pkg::MODE_AUTO;
            nmea_rmc_pkg::CH_D: mode = nmea_rmc_pkg::MODE_DIFF;
            nmea_rmc_pkg::CH_R: mode = nmea_rmc_pkg::MODE_RTK;
            nmea_rmc_pkg::CH_F: mode = nmea_rmc_pkg::MODE_FLOAT;
            nmea_rmc_pkg::CH_E: mode = nmea_rmc_pkg::MODE_EST;
            default:            mode = nmea_rmc_pkg::MODE_OTHER;
        endcase
        close_field();
        p_active = 1'b0;
        p_field  = 4'd0;
        fix = p_kept;
        fix.fix_mode = mode;
        fix.pad = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // sentence generation
    // ------------------------------------------------------------------
    task automatic push_ch(input logic [7:0] c);
        char_q.push_back(c);
        n_items++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_ch(s[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n)
            push_ch(nmea_rmc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // any byte that does not change the sentence structure
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == nmea_rmc_pkg::CH_DOLLAR || b == nmea_rmc_pkg::CH_COMMA ||
            b == nmea_rmc_pkg::CH_STAR)
            b = b ^ 8'h40;
        return b;
    endfunction

    task automatic gen_clock_field();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick != 0)
        begin
            push_digits((pick < 7) ? 6 : $urandom_range(1, 9));
            if ($urandom_range(0, 2) != 0)
            begin
                push_ch(nmea_rmc_pkg::CH_POINT);
                push_digits($urandom_range(0, 3));
            end
            if (pick == 9)
                push_ch(plain_byte());
        end
    endtask

    task automatic gen_decimal(input int whole);
        int pick;
        pick = $urandom_range(0, 11);
        if (pick != 0)
        begin
            if (pick == 1)
                push_ch(CH_MINUS);
            push_digits((pick == 2) ? $urandom_range(0, 14) : whole);
            if (pick == 7)
                push_ch(plain_byte());
            if (pick != 3)
            begin
                push_ch(nmea_rmc_pkg::CH_POINT);
                push_digits((pick == 4) ? $urandom_range(0, 9) : $urandom_range(0, 6));
            end
            if (pick == 5)
                push_ch(plain_byte());
            if (pick == 6)
            begin
                push_ch(nmea_rmc_pkg::CH_POINT);
                push_digits(2);
            end
        end
    endtask

    task automatic gen_letter(input logic [7:0] a, input logic [7:0] b);
        case ($urandom_range(0, 6))
            0, 1: push_ch(a);
            2, 3: push_ch(b);
            4:    push_ch(plain_byte());
            5:    ;
            default:
            begin
                push_ch(8'h00);
                push_ch(a);
            end
        endcase
    endtask

    task automatic gen_mode();
        case ($urandom_range(0, 7))
            0:       push_ch(nmea_rmc_pkg::CH_A);
            1:       push_ch(nmea_rmc_pkg::CH_D);
            2:       push_ch(nmea_rmc_pkg::CH_R);
            3:       push_ch(nmea_rmc_pkg::CH_F);
            4:       push_ch(nmea_rmc_pkg::CH_E);
            5:       push_ch(nmea_rmc_pkg::CH_N);
            6:       push_ch(plain_byte());
            default: ;
        endcase
    endtask

    task automatic gen_sentence();
        int last;
        int f;
        push_ch(nmea_rmc_pkg::CH_DOLLAR);
        repeat ($urandom_range(0, 5))
            push_ch(8'($urandom_range(8'h41, 8'h5A)));
        case ($urandom_range(0, 15))
            0, 1:    last = $urandom_range(0, 11);
            2:       last = $urandom_range(13, 20);
            default: last = 12;
        endcase
        for (f = 1; f <= last; f++)
        begin
            push_ch(nmea_rmc_pkg::CH_COMMA);
            if ($urandom_range(0, 59) == 0)
                push_ch(nmea_rmc_pkg::CH_DOLLAR);
            case (f)
                1, 9:    gen_clock_field();
                2:       gen_letter(nmea_rmc_pkg::CH_A, CH_V);
                3:       gen_decimal(4);
                4:       gen_letter(nmea_rmc_pkg::CH_N, nmea_rmc_pkg::CH_S);
                5:       gen_decimal(5);
                6, 11:   gen_letter(nmea_rmc_pkg::CH_E, nmea_rmc_pkg::CH_W);
                7:       gen_decimal($urandom_range(1, 3));
                8, 10:   gen_decimal(3);
                12:      gen_mode();
                default: push_digits($urandom_range(0, 2));
            endcase
        end
        push_ch(nmea_rmc_pkg::CH_STAR);
        // checksum and line end fall outside the sentence
        if ($urandom_range(0, 1) == 1)
        begin
            push_ch(nmea_rmc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            push_ch(nmea_rmc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            push_ch(CH_CR);
            push_ch(CH_LF);
        end
        // line noise, possibly with stray '$' or '*'
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6))
                push_ch(8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        while (char_q.size() != 0 || s_tvalid || fix_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (rmc_parse_char(s_tdata, fix_pred))
                    fix_q.push_back(fix_pred);
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (char_q.size() == 0)
                    s_tvalid <= 1'b0;
                else if (!calm && $urandom_range(0, 7) == 0)
                begin
                    tx_gap   <= $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tdata  <= char_q.pop_front();
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_gap    <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                fix_got = nmea_rmc_pkg::rmc_result_t'(m_tdata);
                if (fix_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: fix with none expected, actual %h", $time, m_tdata);
                end
                else
                begin
                    fix_want = fix_q.pop_front();
                    check_field("hours", fix_want.hours, fix_got.hours);
                    check_field("minutes", fix_want.minutes, fix_got.minutes);
                    check_field("seconds", fix_want.seconds, fix_got.seconds);
                    check_field("fix_valid", fix_want.fix_valid, fix_got.fix_valid);
                    check_field("latitude", fix_want.latitude, fix_got.latitude);
                    check_field("longitude", fix_want.longitude, fix_got.longitude);
                    check_field("hemispheres", fix_want.hemispheres, fix_got.hemispheres);
                    check_field("speed", fix_want.speed, fix_got.speed);
                    check_field("day", fix_want.day, fix_got.day);
                    check_field("month", fix_want.month, fix_got.month);
                    check_field("year", fix_want.year, fix_got.year);
                    check_field("fix_mode", fix_want.fix_mode, fix_got.fix_mode);
                    check_field("pad", fix_want.pad, fix_got.pad);
                end
            end
            // one long stall so the result register fills and the input backs up
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rx_gap   <= $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // junk before the start, doubled '$', every field empty
        push_text("q$$,,,,,,,,,,,,*");
        // short time, sign in latitude, point-first speed, early end
        push_text("$,1,A,-5,S,,W,.5e*");
        // hemispheres back to north/east, mode taken from the E/W field
        push_text("$,,V,,N,,E*");
        drain();

        hold_req = 1'b1;
        repeat (8)
            push_text("$,12,A*");
        drain();

        while (n_items < ITEMS - CALM_ITEMS)
        begin
            gen_sentence();
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        drain();

        calm = 1'b1;
        repeat (4)
            gen_sentence();
        drain();
        repeat (10) @(negedge clk);

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
